// File: hw/rtl/pidf_pkg.sv
// Shared widths, register indexes, types and the saturation helper of the filtered-input PID.
package pidf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ACC_W       = 32;
    localparam int A_W         = ACC_W + 9;
    localparam int B_W         = 18;
    localparam int PROD_W      = A_W + B_W;
    localparam int GAIN_W      = 16;
    localparam int ALPHA_W     = 17;
    localparam int ILIM_W      = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int OUT_DATA_W  = 5 * ACC_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd7;

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [A_W-1:0]    t_opa;
    typedef logic signed [B_W-1:0]    t_opb;
    typedef logic signed [PROD_W-1:0] t_prod;

    // Clip a wide signed value to the accumulator range.
    function automatic t_acc sat_acc(input t_prod v);
        t_acc res;
        if ((&v[PROD_W-1:ACC_W-1]) || !(|v[PROD_W-1:ACC_W-1])) begin
            res = v[ACC_W-1:0];
        end else if (v[PROD_W-1]) begin
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/pidf_mul.sv
// Shared signed multiplier with a registered product.
module pidf_mul (
    input  logic                 i_clk,
    input  pidf_pkg::t_opa       i_a,
    input  pidf_pkg::t_opb       i_b,
    output pidf_pkg::t_prod      o_prod
);
    import pidf_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/pid_controller_filtered_input.sv
// Top level of the PID controller with a low-pass filtered input, built on one shared multiplier.
// One error sample enters per request on the slave stream; tuser carries the integral-clear and
// filter-restart flags, which act before the sample. The sample is scaled to Q16.16 and, in
// filter mode 0, low-pass filtered with the precomputed alpha; the derivative is the filtered
// change times step_rate. In filter mode 1 the sample is kept raw and only the derivative is
// filtered. The first sample after reset or a restart primes the filter and zeroes the rate.
// The integral runs only while gain_i and step_time are nonzero and clamps to +/- the limit.
// The result enters the output register after a sequencer walks six products through one
// registered 41x18 multiplier, each with an operand-select state and then a state that uses
// the product, and a final state forms the sums. The sequencer returns to idle before it takes
// the next request, so a new request waits until the previous one has finished its walk. The
// block is busy during that walk; a finished result waits in the output register, so the next
// request is taken while it is still unread, and only the final load waits on the master side.
// Configuration writes are always ready and must be issued only while the block is idle.
module pid_controller_filtered_input (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [pidf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input samples
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pidf_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample
    input  logic [1:0]                          s_axis_tuser,  // clear_integral, restart_filter
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pidf_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // p_term, i_term, d_term,
                                                               // pi_sum, pid_sum
);
    import pidf_pkg::*;

    // sequencer codes: M* states select operands, R* states use the product
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_M_DIFF = 4'd1;
    localparam logic [3:0] ST_R_DIFF = 4'd2;
    localparam logic [3:0] ST_M_RATE = 4'd3;
    localparam logic [3:0] ST_R_RATE = 4'd4;
    localparam logic [3:0] ST_M_P    = 4'd5;
    localparam logic [3:0] ST_R_P    = 4'd6;
    localparam logic [3:0] ST_M_T    = 4'd7;
    localparam logic [3:0] ST_R_T    = 4'd8;
    localparam logic [3:0] ST_M_I    = 4'd9;
    localparam logic [3:0] ST_R_I    = 4'd10;
    localparam logic [3:0] ST_M_D    = 4'd11;
    localparam logic [3:0] ST_R_D    = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;

    // configuration registers
    logic [GAIN_W-1:0]  r_gain_p, n_gain_p;
    logic [GAIN_W-1:0]  r_gain_i, n_gain_i;
    logic [GAIN_W-1:0]  r_gain_d, n_gain_d;
    logic [ILIM_W-1:0]  r_ilim, n_ilim;
    logic [ALPHA_W-1:0] r_alpha, n_alpha;
    logic [GAIN_W-1:0]  r_step_time, n_step_time;
    logic [GAIN_W-1:0]  r_step_rate, n_step_rate;
    logic               r_mode, n_mode;

    // controller state
    logic [3:0] r_state, n_state;
    t_acc       r_fv, n_fv;
    t_acc       r_rate, n_rate;
    t_acc       r_integral, n_integral;
    logic       r_needs_prime, n_needs_prime;

    // per-item working registers
    t_acc r_x, n_x;
    t_opa r_tmp, n_tmp;
    t_acc r_p, n_p;
    t_acc r_i, n_i;
    t_acc r_d, n_d;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // multiplier
    t_opa  w_mul_a;
    t_opb  w_mul_b;
    t_prod w_prod;

    logic                          w_in_accept;
    logic                          w_out_free;
    logic                          w_i_on;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    t_prod                         w_x_wide;
    t_acc                          w_x;
    t_prod                         w_sh8;
    t_prod                         w_sh16;
    t_prod                         w_lim;
    t_prod                         w_acc;
    t_prod                         w_sum_pi;
    t_prod                         w_sum_pid;
    t_acc                          w_der;

    pidf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_i_on      = (r_gain_i != '0) && (r_step_time != '0);

    assign w_sample = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_x_wide = PROD_W'(w_sample) <<< FRAC_BITS;
    assign w_x      = sat_acc(w_x_wide);

    // floor shifts of the registered product
    assign w_sh8  = w_prod >>> 8;
    assign w_sh16 = w_prod >>> 16;
    assign w_lim  = PROD_W'({1'b0, r_ilim});
    assign w_acc  = PROD_W'(r_integral) + w_sh16;
    assign w_der  = sat_acc(w_prod);

    assign w_sum_pi  = PROD_W'(r_p) + PROD_W'(r_i);
    assign w_sum_pid = w_sum_pi + PROD_W'(r_d);

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_M_DIFF: begin
                w_mul_a = A_W'(r_x) - A_W'(r_fv);
                w_mul_b = r_mode ? B_W'({1'b0, r_step_rate}) : B_W'({1'b0, r_alpha});
            end
            ST_M_RATE: begin
                w_mul_a = r_tmp;
                w_mul_b = r_mode ? B_W'({1'b0, r_alpha}) : B_W'({1'b0, r_step_rate});
            end
            ST_M_P: begin
                w_mul_a = A_W'(r_fv);
                w_mul_b = B_W'({1'b0, r_gain_p});
            end
            ST_M_T: begin
                w_mul_a = A_W'(r_fv);
                w_mul_b = B_W'({1'b0, r_gain_i});
            end
            ST_M_I: begin
                w_mul_a = r_tmp;
                w_mul_b = B_W'({1'b0, r_step_time});
            end
            ST_M_D: begin
                w_mul_a = A_W'(r_rate);
                w_mul_b = B_W'({1'b0, r_gain_d});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb begin
        n_gain_p      = r_gain_p;
        n_gain_i      = r_gain_i;
        n_gain_d      = r_gain_d;
        n_ilim        = r_ilim;
        n_alpha       = r_alpha;
        n_step_time   = r_step_time;
        n_step_rate   = r_step_rate;
        n_mode        = r_mode;
        n_state       = r_state;
        n_fv          = r_fv;
        n_rate        = r_rate;
        n_integral    = r_integral;
        n_needs_prime = r_needs_prime;
        n_x           = r_x;
        n_tmp         = r_tmp;
        n_p           = r_p;
        n_i           = r_i;
        n_d           = r_d;
        n_out_data    = r_out_data;
        n_out_valid   = r_out_valid && !m_axis_tready;

        // register write; alpha is held already clamped to one
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                CFG_GAIN_P:      n_gain_p    = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:      n_gain_i    = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:      n_gain_d    = i_cfg_data[GAIN_W-1:0];
                CFG_ILIM:        n_ilim      = i_cfg_data[ILIM_W-1:0];
                CFG_ALPHA:       n_alpha     = (i_cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ?
                                               ALPHA_ONE : i_cfg_data[ALPHA_W-1:0];
                CFG_STEP_TIME:   n_step_time = i_cfg_data[GAIN_W-1:0];
                CFG_STEP_RATE:   n_step_rate = i_cfg_data[GAIN_W-1:0];
                CFG_FILTER_MODE: n_mode      = i_cfg_data[0];
                default:         n_mode      = r_mode;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    // apply the flags, then prime if requested
                    n_x = w_x;
                    if (s_axis_tuser[0]) begin
                        n_integral = '0;
                    end
                    if (s_axis_tuser[1] || r_needs_prime) begin
                        n_fv   = w_x;
                        n_rate = '0;
                    end
                    n_needs_prime = 1'b0;
                    n_state       = ST_M_DIFF;
                end
            end
            ST_M_DIFF: n_state = ST_R_DIFF;
            ST_R_DIFF: begin
                if (r_mode) begin
                    // hold der - rate for the filter product
                    n_tmp = A_W'(w_der) - A_W'(r_rate);
                end else begin
                    n_tmp = A_W'(w_sh16);
                    n_fv  = sat_acc(PROD_W'(r_fv) + w_sh16);
                end
                n_state = ST_M_RATE;
            end
            ST_M_RATE: n_state = ST_R_RATE;
            ST_R_RATE: begin
                if (r_step_time != '0) begin
                    n_rate = r_mode ? sat_acc(PROD_W'(r_rate) + w_sh16) : sat_acc(w_prod);
                end
                if (r_mode) begin
                    n_fv = r_x;
                end
                n_state = ST_M_P;
            end
            ST_M_P: n_state = ST_R_P;
            ST_R_P: begin
                n_p     = sat_acc(w_sh8);
                n_state = ST_M_T;
            end
            ST_M_T: n_state = ST_R_T;
            ST_R_T: begin
                n_tmp   = A_W'(w_sh8);
                n_state = ST_M_I;
            end
            ST_M_I: n_state = ST_R_I;
            ST_R_I: begin
                if (w_i_on) begin
                    // clamp to the integral limit
                    if (w_acc > w_lim) begin
                        n_integral = ACC_W'(w_lim);
                    end else if (w_acc < -w_lim) begin
                        n_integral = ACC_W'(-w_lim);
                    end else begin
                        n_integral = ACC_W'(w_acc);
                    end
                    n_i = n_integral;
                end else begin
                    n_i = '0;
                end
                n_state = ST_M_D;
            end
            ST_M_D: n_state = ST_R_D;
            ST_R_D: begin
                n_d     = sat_acc(w_sh8);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // load the result once the output register is free
                if (w_out_free) begin
                    n_out_data  = {sat_acc(w_sum_pid), sat_acc(w_sum_pi), r_d, r_i, r_p};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= GAIN_W'(256);
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_ilim        <= '0;
            r_alpha       <= ALPHA_ONE;
            r_step_time   <= '0;
            r_step_rate   <= '0;
            r_mode        <= 1'b0;
            r_state       <= ST_IDLE;
            r_fv          <= '0;
            r_rate        <= '0;
            r_integral    <= '0;
            r_needs_prime <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_gain_p      <= n_gain_p;
            r_gain_i      <= n_gain_i;
            r_gain_d      <= n_gain_d;
            r_ilim        <= n_ilim;
            r_alpha       <= n_alpha;
            r_step_time   <= n_step_time;
            r_step_rate   <= n_step_rate;
            r_mode        <= n_mode;
            r_state       <= n_state;
            r_fv          <= n_fv;
            r_rate        <= n_rate;
            r_integral    <= n_integral;
            r_needs_prime <= n_needs_prime;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_tmp      <= n_tmp;
        r_p        <= n_p;
        r_i        <= n_i;
        r_d        <= n_d;
        r_out_data <= n_out_data;
    end

    // an accepted request starts the sequencer and clears the prime request
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ST_M_DIFF) && !r_needs_prime)
        else $error("accepted request did not start the sequence");

    // the integral term never leaves the clamp band
    a_i_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == ST_R_I) |-> (PROD_W'(r_i) <= w_lim) && (PROD_W'(r_i) >= -w_lim))
        else $error("integral term outside the limit");

    // a free output register takes the result and frees the input side
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_free) |=> (r_state == ST_IDLE) && m_axis_tvalid)
        else $error("finished result not loaded");

    // the sequencer never stalls before the output stage
    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_OUT) |=> (r_state != $past(r_state)))
        else $error("sequencer stalled mid item");

endmodule

// File: tb/pid_controller_filtered_input_checker.sv
`timescale 1ns / 100ps
// Checker for the filtered-input PID: tracks register writes, predicts each result, compares.
module pid_controller_filtered_input_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [pidf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [pidf_pkg::IN_DATA_W-1:0]    i_in_data,   // sample
    input  logic [1:0]                        i_in_user,   // clear_integral, restart_filter
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [pidf_pkg::OUT_DATA_W-1:0]   i_out_data,  // p_term, i_term, d_term,
                                                           // pi_sum, pid_sum
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    import pidf_pkg::*;

    localparam int     TERMS   = 5;
    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    logic [GAIN_W-1:0]  kp, ki, kd;
    logic [ILIM_W-1:0]  ilim;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [15:0]        dt_q16;
    logic [15:0]        rate_hz;
    logic               deriv_only;

    int   filt_q, rate_q, integ_q;
    logic prime_q;

    logic [OUT_DATA_W-1:0] expected_terms[$];
    logic [OUT_DATA_W-1:0] want;
    string                 term_names[TERMS] = '{"p_term", "i_term", "d_term", "pi_sum",
                                                 "pid_sum"};
    int                    fail_count = 0;
    int                    checked    = 0;

    function automatic longint clip32(input longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    // Advance the controller state by one sample and return the packed result.
    function automatic logic [OUT_DATA_W-1:0] advance_controller(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic                          clr,
        input logic                          restart
    );
        longint x, a, change, der, upd, p, i, d, t, acc, lim;
        x = longint'(smp) <<< FRAC_BITS;
        a = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);
        if (clr) integ_q = 0;
        if (restart) prime_q = 1'b1;
        if (prime_q) begin
            prime_q = 1'b0;
            filt_q  = int'(x);
            rate_q  = 0;
        end
        if (!deriv_only) begin
            change = (a * (x - longint'(filt_q))) >>> 16;
            filt_q = int'(clip32(longint'(filt_q) + change));
            if (dt_q16 != 0) rate_q = int'(clip32(change * longint'(rate_hz)));
        end else begin
            if (dt_q16 != 0) begin
                der    = clip32((x - longint'(filt_q)) * longint'(rate_hz));
                upd    = (a * (der - longint'(rate_q))) >>> 16;
                rate_q = int'(clip32(longint'(rate_q) + upd));
            end
            filt_q = int'(x);
        end
        p = clip32((longint'(kp) * longint'(filt_q)) >>> 8);
        if (ki != 0 && dt_q16 != 0) begin
            t   = (longint'(filt_q) * longint'(ki)) >>> 8;
            acc = longint'(integ_q) + ((t * longint'(dt_q16)) >>> 16);
            lim = longint'(ilim);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            integ_q = int'(acc);
            i       = acc;
        end else begin
            i = 0;
        end
        d = clip32((longint'(kd) * longint'(rate_q)) >>> 8);
        return {32'(clip32(p + i + d)), 32'(clip32(p + i)), 32'(d), 32'(i), 32'(p)};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp         = 16'd256;
            ki         = '0;
            kd         = '0;
            ilim       = '0;
            alpha_reg  = ALPHA_ONE;
            dt_q16     = '0;
            rate_hz    = '0;
            deriv_only = 1'b0;
            filt_q     = 0;
            rate_q     = 0;
            integ_q    = 0;
            prime_q    = 1'b1;
            expected_terms.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_GAIN_P:      kp = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:      ki = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:      kd = i_cfg_data[GAIN_W-1:0];
                    CFG_ILIM:        ilim = i_cfg_data[ILIM_W-1:0];
                    CFG_ALPHA:       alpha_reg = i_cfg_data[ALPHA_W-1:0];
                    CFG_STEP_TIME:   dt_q16 = i_cfg_data[15:0];
                    CFG_STEP_RATE:   rate_hz = i_cfg_data[15:0];
                    CFG_FILTER_MODE: deriv_only = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_terms.push_back(advance_controller(i_in_data[SAMPLE_BITS-1:0],
                                                            i_in_user[0], i_in_user[1]));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_terms.size() == 0) begin
                    fail_count++;
                    $display("%t: result with no sample waiting: expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = expected_terms.pop_front();
                    checked++;
                    for (int k = 0; k < TERMS; k++) begin
                        if (want[k*ACC_W +: ACC_W] !== i_out_data[k*ACC_W +: ACC_W]) begin
                            fail_count++;
                            $display("%t: %s expected %0d actual %0d", $time, term_names[k],
                                     $signed(want[k*ACC_W +: ACC_W]),
                                     $signed(i_out_data[k*ACC_W +: ACC_W]));
                        end
                    end
                end
            end
        end
        o_pending <= expected_terms.size();
    end

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

endmodule

// File: tb/pid_controller_filtered_input_test.sv
`timescale 1ns / 100ps
// Testbench top for the filtered-input PID: drives samples and register writes, gives the verdict.
module pid_controller_filtered_input_test;
    import pidf_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 119;
    localparam int RESULT_LATENCY  = 14;
    localparam int CYCLE_LIMIT     = 1_000_000;

    // Idle patterns: which side, if any, inserts bubbles into its handshake.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // sample
    logic [1:0]            s_axis_tuser  = '0;  // clear_integral, restart_filter
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // p_term, i_term, d_term, pi_sum, pid_sum

    int fail_count, pending, checked;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int samples_sent   = 0;
    int settings_count = 0;
    int cycle_count;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    pid_controller_filtered_input dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pid_controller_filtered_input_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Stall the result side at random; tready is held low with a chance of stall_pct percent.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pid_controller_filtered_input: mismatch");
        $finish;
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 62; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 62; end
            default:       begin send_idle_pct = 6;  stall_pct = 6;  end
        endcase
    endtask

    // Offer one sample request. Valid stays high on return so that a back-to-back
    // request never lowers and raises it in the same step; gaps and drains drop it.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic clr,
                               input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= {restart, clr};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Hold off new samples until every predicted result has come back.
    // The first edge lets the checker count a request accepted on the edge just past.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Load a full register set; only legal with the block idle, so drain first.
    task automatic program_settings(input logic [15:0] gp, input logic [15:0] gi,
                                    input logic [15:0] gd, input logic [30:0] lim,
                                    input logic [16:0] alpha, input logic [15:0] dt,
                                    input logic [15:0] rate, input logic mode);
        drain_results();
        write_reg(CFG_GAIN_P, CFG_DATA_W'(gp));
        write_reg(CFG_GAIN_I, CFG_DATA_W'(gi));
        write_reg(CFG_GAIN_D, CFG_DATA_W'(gd));
        write_reg(CFG_ILIM, CFG_DATA_W'(lim));
        write_reg(CFG_ALPHA, CFG_DATA_W'(alpha));
        write_reg(CFG_STEP_TIME, CFG_DATA_W'(dt));
        write_reg(CFG_STEP_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(mode));
        i_cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Draw a register value: zero, all ones, a modest value, or anything.
    function automatic logic [30:0] pick_field(input logic [30:0] full, input int unsigned typ);
        case ($urandom_range(7))
            0:       return '0;
            1:       return full;
            2, 3, 4: return 31'($urandom_range(typ)) & full;
            default: return 31'($urandom()) & full;
        endcase
    endfunction

    // Mix rail values, small errors near zero, and the full range.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom_range(512) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [16:0] pick_alpha();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 17'(ALPHA_ONE);
            2:       return 17'($urandom_range(131071, 65537));  // above one, clamps to one
            default: return 17'($urandom_range(65535, 1));
        endcase
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling. Reset registers: unity P only, integral off,
        // first sample primes the filter.
        set_idle(IDLE_NONE);
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(16'h7FFF, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h0001, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b1);

        // All gains, rate and step time at maximum, alpha above one: drive each
        // sum into saturation on the rail samples and the integral to its widest clamp.
        program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 17'h1FFFF,
                         16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h7FFF, 1'b1, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b1);
        send_sample(16'h0000, 1'b1, 1'b1);

        // Derivative-only filtering, zero alpha (rate frozen), zero clamp, no P.
        program_settings(16'h0000, 16'h0001, 16'h0100, 31'h0, 17'h0, 16'h0001, 16'h0001, 1'b1);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h7FFF, 1'b0, 1'b0);
        send_sample(16'(100), 1'b1, 1'b1);
        send_sample(16'(-100), 1'b0, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);

        // Derivative-only with alpha exactly one and a realistic 1 kHz loop.
        program_settings(16'h0080, 16'h0200, 16'h0040, 31'h0010_0000, 17'(ALPHA_ONE),
                         16'h0041, 16'd1000, 1'b1);
        send_sample(16'(1000), 1'b0, 1'b0);
        send_sample(16'(-1000), 1'b0, 1'b0);
        send_sample(16'h7FFF, 1'b0, 1'b0);
        send_sample(16'(-5), 1'b1, 1'b0);

        // Zero step time: rate estimate holds, integral reads zero despite its gain.
        program_settings(16'h0100, 16'h0100, 16'h0100, 31'h7FFF_FFFF, 17'h08000,
                         16'h0000, 16'd500, 1'b0);
        send_sample(16'(2000), 1'b0, 1'b1);
        send_sample(16'(4000), 1'b0, 1'b0);
        send_sample(16'(-4000), 1'b1, 1'b0);

        // Random part: new register set per phase, idle patterns in rotation.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idle(t_idle_mode'(ph % 4));
            program_settings(16'(pick_field(31'hFFFF, 32'h0300)),
                             16'(pick_field(31'hFFFF, 32'h0300)),
                             16'(pick_field(31'hFFFF, 32'h0300)),
                             pick_field(31'h7FFF_FFFF, 32'h0100_0000),
                             pick_alpha(),
                             16'(pick_field(31'hFFFF, 32'h0400)),
                             16'(pick_field(31'hFFFF, 32'd2000)),
                             1'($urandom_range(1)));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Now and then let the pipeline empty before the next request.
                if ($urandom_range(63) == 0) drain_results();
                send_sample(pick_sample(), ($urandom_range(15) == 0), ($urandom_range(15) == 0));
            end
        end

        drain_results();
        repeat (RESULT_LATENCY) @(posedge i_clk);

        $display("Ran %0d error samples over %0d register sets with rotating idle patterns.",
                 samples_sent, settings_count);
        $display("Checked %0d results term by term, %0d errors.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("pid_controller_filtered_input: match");
        end else begin
            $display("pid_controller_filtered_input: mismatch");
        end
        $finish;
    end

endmodule

// File: pid_controller_filtered_input.f
hw/rtl/pidf_pkg.sv
hw/rtl/pidf_mul.sv
hw/rtl/pid_controller_filtered_input.sv
tb/pid_controller_filtered_input_checker.sv
tb/pid_controller_filtered_input_test.sv
